// ----- design/quarter_wave_sincos_interp_unit_assert.svh -----
// Assertion macros shared by the quarter-wave sine/cosine unit.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef QUARTER_WAVE_SINCOS_INTERP_UNIT_ASSERT_SVH
`define QUARTER_WAVE_SINCOS_INTERP_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QWSCI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QWSCI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/qwsci_pkg.sv -----
// Types, constants and helper functions of the quarter-wave sine/cosine unit.
// Depends on nothing; used by quarter_wave_sincos_interp_unit.
package qwsci_pkg;

    localparam int PHASE_W = 16;
    localparam int AMP_W   = 16;
    localparam int MAG_W   = AMP_W - 1;
    localparam int IDX_W   = 7;
    localparam int FRAC_W  = 8;
    localparam int DIFF_W  = 10;
    localparam int PROD_W  = DIFF_W + FRAC_W;

    localparam logic [PHASE_W-1:0] HALF_TURN    = 16'h8000;
    localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'h4000;
    localparam logic [MAG_W-1:0]   FULL_SCALE   = 15'd32767;
    localparam logic [IDX_W-1:0]   ROM_LAST     = 7'd64;
    localparam logic [PROD_W-1:0]  ROUND_HALF   = 18'd128;
    localparam logic [AMP_W-1:0]   MOST_NEG     = 16'h8000;

    // round(sin(k*pi/128) * 32767) for k = 0..64
    localparam logic [MAG_W-1:0] QW_ROM [0:64] = '{
            15'd0,     15'd804,   15'd1608,  15'd2410,  15'd3212,  15'd4011,
            15'd4808,  15'd5602,  15'd6393,  15'd7179,  15'd7962,  15'd8739,
            15'd9512,  15'd10278, 15'd11039, 15'd11793, 15'd12539, 15'd13279,
            15'd14010, 15'd14732, 15'd15446, 15'd16151, 15'd16846, 15'd17530,
            15'd18204, 15'd18868, 15'd19519, 15'd20159, 15'd20787, 15'd21403,
            15'd22005, 15'd22594, 15'd23170, 15'd23731, 15'd24279, 15'd24811,
            15'd25329, 15'd25832, 15'd26319, 15'd26790, 15'd27245, 15'd27683,
            15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956,
            15'd30273, 15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580,
            15'd31785, 15'd31971, 15'd32137, 15'd32285, 15'd32412, 15'd32521,
            15'd32609, 15'd32678, 15'd32728, 15'd32757, 15'd32767
        };

    // Phase folded into the first quarter turn, with the sign it carries.
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] angle;
    } fold_t;

    // Table neighbors and interpolation fraction for one lane.
    typedef struct packed {
        logic              neg;
        logic              sat;
        logic [MAG_W-1:0]  y0;
        logic [DIFF_W-1:0] diff;
        logic [FRAC_W-1:0] frac;
    } look_t;

    // Interpolated magnitude and sign.
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } mag_t;

    function automatic fold_t fold_phase(input logic [PHASE_W-1:0] p);
        fold_t              f;
        logic [PHASE_W-1:0] q;
        f.neg = (p > HALF_TURN);
        q = f.neg ? (p - HALF_TURN) : p;
        if (q > QUARTER_TURN)
        begin
            q = HALF_TURN - q;
        end
        f.angle = q[MAG_W-1:0];
        return f;
    endfunction

    // Entries past the end of the table read as full scale.
    function automatic logic [MAG_W-1:0] rom_word(input logic [IDX_W-1:0] i);
        logic [MAG_W-1:0] w;
        if (i > ROM_LAST)
        begin
            w = FULL_SCALE;
        end
        else
        begin
            w = QW_ROM[i];
        end
        return w;
    endfunction

endpackage

// ----- design/quarter_wave_sincos_interp_unit.sv -----
// Quarter-wave sine/cosine generator with linear interpolation, top level.
// Depends on qwsci_pkg and quarter_wave_sincos_interp_unit_assert.svh.
//
// The unit takes one 16-bit unsigned phase word per clock while s_axis_tready
// is high (65536 steps are one full turn, so the phase wraps by itself) and
// returns sine and cosine of it in signed Q1.15. Each word goes through four
// register stages: the fold into the first quarter turn, the lookup of two
// neighboring entries of a 65-entry quarter-wave table, the linear
// interpolation over the low 8 phase bits with rounding half up, and the
// final sign. Each stage has its own valid bit and moves whenever the
// stage after it is empty or moving, so bubbles close up under back-pressure
// and a finished word may wait at the output while new phases keep entering.
// A quarter turn gives exactly 32767, and negative values stop at -32767.
module quarter_wave_sincos_interp_unit
    import qwsci_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PHASE_W-1:0]   s_axis_tdata,   // [15:0] phase
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [2*AMP_W-1:0]   m_axis_tdata    // [15:0] sin_value, [31:16] cos_value
);

`include "quarter_wave_sincos_interp_unit_assert.svh"

    localparam int STAGES = 4;
    localparam int LANES  = 2;   // lane 0 is sine, lane 1 is cosine

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] adv;

    fold_t            fold_reg  [LANES];
    fold_t            fold_next [LANES];
    look_t            look_reg  [LANES];
    look_t            look_next [LANES];
    mag_t             mag_reg   [LANES];
    mag_t             mag_next  [LANES];
    logic [AMP_W-1:0] out_reg   [LANES];
    logic [AMP_W-1:0] out_next  [LANES];

    logic [IDX_W-1:0]  idx   [LANES];
    logic [IDX_W-1:0]  idx_n [LANES];
    logic [MAG_W-1:0]  y1    [LANES];
    logic [MAG_W-1:0]  dy    [LANES];
    logic [PROD_W-1:0] prod  [LANES];
    logic [MAG_W:0]    sum   [LANES];

    // A stage takes a new word when it is empty or its contents move on.
    always_comb
    begin
        adv[3] = !valid_reg[3] || m_axis_tready;
        adv[2] = !valid_reg[2] || adv[3];
        adv[1] = !valid_reg[1] || adv[2];
        adv[0] = !valid_reg[0] || adv[1];
    end

    assign s_axis_tready = adv[0];

    // Fold: cosine is the sine of the phase advanced by a quarter turn.
    always_comb
    begin
        fold_next[0] = fold_phase(s_axis_tdata);
        fold_next[1] = fold_phase(s_axis_tdata + QUARTER_TURN);
    end

    // Lookup, interpolation and sign for both lanes.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            idx[l]   = fold_reg[l].angle[MAG_W-1:FRAC_W];
            idx_n[l] = idx[l] + 7'd1;
            y1[l]    = rom_word(idx_n[l]);
            look_next[l].neg  = fold_reg[l].neg;
            look_next[l].sat  = (idx[l] >= ROM_LAST);
            look_next[l].y0   = rom_word(idx[l]);
            look_next[l].frac = fold_reg[l].angle[FRAC_W-1:0];
            dy[l]             = y1[l] - look_next[l].y0;
            look_next[l].diff = dy[l][DIFF_W-1:0];

            prod[l] = look_reg[l].diff * look_reg[l].frac + ROUND_HALF;
            sum[l]  = {1'b0, look_reg[l].y0}
                    + {{(MAG_W+1-(PROD_W-FRAC_W)){1'b0}}, prod[l][PROD_W-1:FRAC_W]};
            mag_next[l].neg = look_reg[l].neg;
            mag_next[l].mag = look_reg[l].sat ? FULL_SCALE : sum[l][MAG_W-1:0];

            out_next[l] = mag_reg[l].neg ? (16'd0 - {1'b0, mag_reg[l].mag})
                                         : {1'b0, mag_reg[l].mag};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int s = 1; s < STAGES; s++)
            begin
                if (adv[s])
                begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (adv[0] && s_axis_tvalid)
            begin
                fold_reg[l] <= fold_next[l];
            end
            if (adv[1] && valid_reg[0])
            begin
                look_reg[l] <= look_next[l];
            end
            if (adv[2] && valid_reg[1])
            begin
                mag_reg[l] <= mag_next[l];
            end
            if (adv[3] && valid_reg[2])
            begin
                out_reg[l] <= out_next[l];
            end
        end
    end

    assign m_axis_tvalid = valid_reg[3];
    assign m_axis_tdata  = {out_reg[1], out_reg[0]};

    `QWSCI_ASSERT_NEXT(a_accept_fills, s_axis_tvalid && s_axis_tready, valid_reg[0], "accepted phase did not enter the pipeline")
    `QWSCI_ASSERT_NEXT(a_stall_holds, valid_reg[0] && !adv[0], valid_reg[0] && $stable(fold_reg[0]) && $stable(fold_reg[1]), "stalled fold stage changed")
    `QWSCI_ASSERT_SAME(a_sat_exact, valid_reg[1] && (look_reg[0].sat || look_reg[1].sat), (!look_reg[0].sat || look_reg[0].frac == 8'd0) && (!look_reg[1].sat || look_reg[1].frac == 8'd0), "table end reached off an exact quarter turn")
    `QWSCI_ASSERT_SAME(a_no_most_neg, valid_reg[3], out_reg[0] != MOST_NEG && out_reg[1] != MOST_NEG, "output reached the most negative code")

endmodule

// ----- tb/sv/quarter_wave_sincos_interp_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for quarter_wave_sincos_interp_unit.
// Depends on qwsci_pkg for port widths and on the unit itself, nothing else.
module quarter_wave_sincos_interp_unit_tb
    import qwsci_pkg::*;
();

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_WORDS  = 1200;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 20;

    // Angle arithmetic of the expected-value model, in phase steps.
    localparam int TURN_HALF     = 32768;
    localparam int TURN_QUARTER  = 16384;
    localparam int INTERP_BITS   = 8;
    localparam int SEGMENTS      = 64;
    localparam int PEAK          = 32767;

    // Points in the run where the flow-control pressure is applied.
    localparam int HOLD_AT_WORD  = 200;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_AT_WORD = 700;

    // One expected output word, tagged with the phase that caused it.
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [AMP_W-1:0]   sin_value;
        logic [AMP_W-1:0]   cos_value;
    } sincos_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [PHASE_W-1:0]   s_axis_tdata;   // [15:0] phase
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [2*AMP_W-1:0]   m_axis_tdata;   // [15:0] sin_value, [31:16] cos_value

    // Quarter-wave sine samples in Q15, sin(k*pi/128) for k = 0..64.
    int sine_table [0:64] = '{
            0,   804,  1608,  2410,  3212,  4011,  4808,  5602,
         6393,  7179,  7962,  8739,  9512, 10278, 11039, 11793,
        12539, 13279, 14010, 14732, 15446, 16151, 16846, 17530,
        18204, 18868, 19519, 20159, 20787, 21403, 22005, 22594,
        23170, 23731, 24279, 24811, 25329, 25832, 26319, 26790,
        27245, 27683, 28105, 28510, 28898, 29268, 29621, 29956,
        30273, 30571, 30852, 31113, 31356, 31580, 31785, 31971,
        32137, 32285, 32412, 32521, 32609, 32678, 32728, 32757,
        32767
    };

    logic [PHASE_W-1:0] phase_q [$];      // phases still to be offered
    sincos_t            sincos_q [$];     // predicted words, oldest first

    int  mismatch_count;
    int  sent_count;
    int  received_count;
    int  cycle_count;

    // Sender-side flow state.
    int  tx_gap_left;
    int  tx_burst_left;
    bit  draining;
    bit  drain_done;

    // Receiver-side flow state.
    int  rx_stall_left;
    int  rx_burst_left;
    int  hold_left;
    bit  hold_done;

    quarter_wave_sincos_interp_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // Signed sine of a phase word. The phase is folded into the first
    // quarter turn: past half a turn the sign flips and half a turn comes
    // off, past a quarter turn the angle is mirrored about a quarter turn.
    // The top bits pick a table segment and the low 8 bits interpolate
    // inside it, rounding half up. The far end of the table is full scale.
    function automatic logic [AMP_W-1:0] sine_of(input logic [PHASE_W-1:0] ph);
        int angle;
        int seg;
        int lo;
        int hi;
        int mag;
        bit negate;
        angle  = int'(ph);
        negate = 1'b0;
        if (angle > TURN_HALF)
        begin
            angle  = angle - TURN_HALF;
            negate = 1'b1;
        end
        if (angle > TURN_QUARTER)
        begin
            angle = TURN_HALF - angle;
        end
        seg = angle >> INTERP_BITS;
        if (seg >= SEGMENTS)
        begin
            mag = PEAK;
        end
        else
        begin
            lo  = sine_table[seg];
            hi  = sine_table[seg + 1];
            mag = lo + (((hi - lo) * (angle & ((1 << INTERP_BITS) - 1))
                         + (1 << (INTERP_BITS - 1))) >> INTERP_BITS);
            if (mag > PEAK)
            begin
                mag = PEAK;
            end
        end
        if (negate)
        begin
            mag = -mag;
        end
        return mag[AMP_W-1:0];
    endfunction

    // Cosine is the sine a quarter turn further on, wrapping at one turn.
    function automatic sincos_t predict_sincos(input logic [PHASE_W-1:0] ph);
        sincos_t            r;
        logic [PHASE_W-1:0] ahead;
        ahead       = ph + PHASE_W'(TURN_QUARTER);
        r.phase     = ph;
        r.sin_value = sine_of(ph);
        r.cos_value = sine_of(ahead);
        return r;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Random phase biased toward the places where the folding and the
    // table lookup change behavior; the rest is spread over the whole turn.
    function automatic logic [PHASE_W-1:0] random_phase();
        int r;
        int base;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            base = $urandom_range(0, 3) * TURN_QUARTER;
            return PHASE_W'(base + $urandom_range(0, 8) - 4);
        end
        else if (r < 30)
        begin
            base = $urandom_range(0, 255) << INTERP_BITS;
            case ($urandom_range(0, 4))
                0: return PHASE_W'(base);
                1: return PHASE_W'(base + 1);
                2: return PHASE_W'(base + 127);
                3: return PHASE_W'(base + 128);
                default: return PHASE_W'(base + 255);
            endcase
        end
        return PHASE_W'($urandom_range(0, 65535));
    endfunction

    task automatic report_mismatch(input string what, input logic [PHASE_W-1:0] ph,
                                   input logic [AMP_W-1:0] want,
                                   input logic [AMP_W-1:0] got);
        $display("%0t: mismatch in %s for phase 0x%04h: expected %0d, got %0d",
                 $realtime, what, ph, $signed(want), $signed(got));
        mismatch_count = mismatch_count + 1;
    endtask

    // Driver. Every accepted phase word is predicted at the edge that takes
    // it. The valid line changes only when no word is pending, and each
    // output gets a single nonblocking assignment per edge. Once, the
    // sender holds back until every predicted word has come out.
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic               next_valid;
        logic [PHASE_W-1:0] next_data;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            tx_gap_left   = 0;
            tx_burst_left = 0;
            draining      = 1'b0;
            drain_done    = 1'b0;
            sent_count    = 0;
        end
        else
        begin
            next_valid = s_axis_tvalid;
            next_data  = s_axis_tdata;
            if (s_axis_tvalid && s_axis_tready)
            begin
                sincos_q.push_back(predict_sincos(s_axis_tdata));
                sent_count = sent_count + 1;
                next_valid = 1'b0;
                if (sent_count == DRAIN_AT_WORD && !drain_done)
                begin
                    draining = 1'b1;
                end
            end
            if (!next_valid)
            begin
                if (draining)
                begin
                    if (sincos_q.size() == 0)
                    begin
                        draining   = 1'b0;
                        drain_done = 1'b1;
                    end
                end
                else if (tx_gap_left > 0)
                begin
                    tx_gap_left = tx_gap_left - 1;
                end
                else if (phase_q.size() > 0)
                begin
                    next_data  = phase_q.pop_front();
                    next_valid = 1'b1;
                    // Back-to-back stretches alternate with random gaps.
                    if (tx_burst_left > 0)
                    begin
                        tx_burst_left = tx_burst_left - 1;
                        tx_gap_left   = 0;
                    end
                    else
                    begin
                        tx_gap_left = idle_length();
                        if ($urandom_range(0, 19) == 0)
                        begin
                            tx_burst_left = $urandom_range(20, 80);
                        end
                    end
                end
            end
            s_axis_tvalid <= next_valid;
            s_axis_tdata  <= next_data;
        end
    end

    // Monitor. Each accepted output word is checked field by field against
    // the oldest prediction. The ready line stalls at random, runs freely
    // in bursts, and once holds off long enough for the pipeline to fill
    // and push back on the sender.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        sincos_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_stall_left  = 0;
            rx_burst_left  = 0;
            hold_left      = 0;
            hold_done      = 1'b0;
            received_count = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                received_count = received_count + 1;
                if (sincos_q.size() == 0)
                begin
                    $display("%0t: output word 0x%08h with no prediction pending",
                             $realtime, m_axis_tdata);
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    want = sincos_q.pop_front();
                    if (m_axis_tdata[AMP_W-1:0] !== want.sin_value)
                    begin
                        report_mismatch("sin_value", want.phase, want.sin_value,
                                        m_axis_tdata[AMP_W-1:0]);
                    end
                    if (m_axis_tdata[2*AMP_W-1:AMP_W] !== want.cos_value)
                    begin
                        report_mismatch("cos_value", want.phase, want.cos_value,
                                        m_axis_tdata[2*AMP_W-1:AMP_W]);
                    end
                end
                if (received_count == HOLD_AT_WORD && !hold_done)
                begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (rx_stall_left > 0)
            begin
                rx_stall_left = rx_stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (rx_burst_left > 0)
                begin
                    rx_burst_left = rx_burst_left - 1;
                end
                else if ($urandom_range(0, 2) == 0)
                begin
                    rx_stall_left = idle_length();
                end
                else if ($urandom_range(0, 29) == 0)
                begin
                    rx_burst_left = $urandom_range(20, 80);
                end
            end
        end
    end

    // A run that stops moving ends here.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Reset, stimulus and the end of the run.
    initial
    begin : stimulus
        int i;
        mismatch_count = 0;
        cycle_count    = 0;
        rst_n          = 1'b0;

        // Directed words: both ends of the phase range, every quadrant
        // boundary with its neighbors (the exact quarter turn reaches the
        // end of the table and saturates, the exact half turn is not
        // negated), the smallest negative results, and interpolation
        // fractions of zero, one half and almost one.
        phase_q.push_back(16'h0000);
        phase_q.push_back(16'hFFFF);
        phase_q.push_back(16'h0001);
        phase_q.push_back(16'h3FFF);
        phase_q.push_back(16'h4000);
        phase_q.push_back(16'h4001);
        phase_q.push_back(16'h7FFF);
        phase_q.push_back(16'h8000);
        phase_q.push_back(16'h8001);
        phase_q.push_back(16'hBFFF);
        phase_q.push_back(16'hC000);
        phase_q.push_back(16'hC001);
        phase_q.push_back(16'h0080);
        phase_q.push_back(16'h00FF);
        phase_q.push_back(16'h0100);
        phase_q.push_back(16'h3F80);
        phase_q.push_back(16'h3FFE);
        phase_q.push_back(16'h2000);
        phase_q.push_back(16'h6000);
        phase_q.push_back(16'hA000);
        phase_q.push_back(16'hE000);
        phase_q.push_back(16'h5555);
        phase_q.push_back(16'hAAAA);

        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            phase_q.push_back(random_phase());
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (phase_q.size() > 0 || s_axis_tvalid)
        begin
            @(posedge clk);
        end
        while (sincos_q.size() > 0)
        begin
            @(posedge clk);
        end
        // Let any stray word that the unit might still emit show up.
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
